FILE: rtl/ddcm_pkg.sv
// ----------------------------------------------------------------------------
// Drive command mixer package
// Shared codes, reset values, configuration and command types for the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddcm_pkg;

   // command codes carried in the action field
   localparam logic [3:0] ActCrawl    = 4'd0;
   localparam logic [3:0] ActSlow     = 4'd1;
   localparam logic [3:0] ActFast     = 4'd2;
   localparam logic [3:0] ActForward  = 4'd3;
   localparam logic [3:0] ActUturn    = 4'd7;
   localparam logic [3:0] ActSetSpeed = 4'd9;

   // move codes
   localparam logic [2:0] MoveStop    = 3'd0;
   localparam logic [2:0] MoveForward = 3'd1;
   localparam logic [2:0] MoveBack    = 3'd2;
   localparam logic [2:0] MoveLeft    = 3'd3;
   localparam logic [2:0] MoveRight   = 3'd4;
   localparam logic [2:0] MoveUturn   = 3'd5;

   // side direction codes
   localparam logic [1:0] DirIdle = 2'd0;
   localparam logic [1:0] DirFwd  = 2'd1;
   localparam logic [1:0] DirRev  = 2'd2;

   // enable modes
   localparam logic [1:0] ModeLow  = 2'd0;
   localparam logic [1:0] ModePwm  = 2'd1;
   localparam logic [1:0] ModeHigh = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [2:0] RegCrawl     = 3'd0;
   localparam logic [2:0] RegSlow      = 3'd1;
   localparam logic [2:0] RegFast      = 3'd2;
   localparam logic [2:0] RegDefault   = 3'd3;
   localparam logic [2:0] RegInner     = 3'd4;
   localparam logic [2:0] RegOuter     = 3'd5;
   localparam logic [2:0] RegFullScale = 3'd6;

   // register reset values
   localparam logic [6:0]  CrawlReset     = 7'd10;
   localparam logic [6:0]  SlowReset      = 7'd40;
   localparam logic [6:0]  FastReset      = 7'd90;
   localparam logic [6:0]  DefaultReset   = 7'd40;
   localparam logic [6:0]  InnerReset     = 7'd50;
   localparam logic [6:0]  OuterReset     = 7'd100;
   localparam logic [15:0] FullScaleReset = 16'd1023;

   localparam logic [6:0] PctMax = 7'd100;

   // x / 100 = (x * floor(2^24 / 100)) >> 24, low by at most one for x < 2^23
   localparam int unsigned RecipShift = 24;
   localparam logic [17:0] RecipDiv100 = 18'd167772;

   // scaling passes of the shared multiplier
   localparam logic [1:0] OpInner     = 2'd0;
   localparam logic [1:0] OpOuter     = 2'd1;
   localparam logic [1:0] OpDutyLeft  = 2'd2;
   localparam logic [1:0] OpDutyRight = 2'd3;

   typedef struct packed {
      logic [6:0]  crawl_speed;
      logic [6:0]  slow_speed;
      logic [6:0]  fast_speed;
      logic [6:0]  default_speed;
      logic [6:0]  inner_turn_pct;
      logic [6:0]  outer_turn_pct;
      logic [15:0] pwm_full_scale;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       mul1;
      logic       mul2;
      logic       fix;
      logic       mix;
      logic       out_load;
      logic [1:0] op;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/ddcm_regs.sv
// ----------------------------------------------------------------------------
// Drive command mixer registers
// APB-style register file holding speed presets, turn ratios and PWM scale.
// ----------------------------------------------------------------------------
`default_nettype none

module ddcm_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output ddcm_pkg::cfg_type     cfg
);

   ddcm_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index = csr_paddr[4:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            ddcm_pkg::RegCrawl:     cfg_in.crawl_speed    = csr_pwdata[6:0];
            ddcm_pkg::RegSlow:      cfg_in.slow_speed     = csr_pwdata[6:0];
            ddcm_pkg::RegFast:      cfg_in.fast_speed     = csr_pwdata[6:0];
            ddcm_pkg::RegDefault:   cfg_in.default_speed  = csr_pwdata[6:0];
            ddcm_pkg::RegInner:     cfg_in.inner_turn_pct = csr_pwdata[6:0];
            ddcm_pkg::RegOuter:     cfg_in.outer_turn_pct = csr_pwdata[6:0];
            ddcm_pkg::RegFullScale: cfg_in.pwm_full_scale = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crawl_speed    <= ddcm_pkg::CrawlReset;
         cfg_ff.slow_speed     <= ddcm_pkg::SlowReset;
         cfg_ff.fast_speed     <= ddcm_pkg::FastReset;
         cfg_ff.default_speed  <= ddcm_pkg::DefaultReset;
         cfg_ff.inner_turn_pct <= ddcm_pkg::InnerReset;
         cfg_ff.outer_turn_pct <= ddcm_pkg::OuterReset;
         cfg_ff.pwm_full_scale <= ddcm_pkg::FullScaleReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         ddcm_pkg::RegCrawl:     csr_prdata = {25'd0, cfg_ff.crawl_speed};
         ddcm_pkg::RegSlow:      csr_prdata = {25'd0, cfg_ff.slow_speed};
         ddcm_pkg::RegFast:      csr_prdata = {25'd0, cfg_ff.fast_speed};
         ddcm_pkg::RegDefault:   csr_prdata = {25'd0, cfg_ff.default_speed};
         ddcm_pkg::RegInner:     csr_prdata = {25'd0, cfg_ff.inner_turn_pct};
         ddcm_pkg::RegOuter:     csr_prdata = {25'd0, cfg_ff.outer_turn_pct};
         ddcm_pkg::RegFullScale: csr_prdata = {16'd0, cfg_ff.pwm_full_scale};
         default:                csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/ddcm_dpath.sv
// ----------------------------------------------------------------------------
// Drive command mixer datapath
// Speed and move state, held mix, one shared multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddcm_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ddcm_pkg::cmd_type cmd,
   input  wire ddcm_pkg::cfg_type cfg,
   input  wire logic [15:0]       req_tdata,
   output logic [63:0]            rsp_tdata
);

   logic [3:0]  action;
   logic [7:0]  sv_raw;
   logic [6:0]  preset, preset_clamp, sv_clamp;

   logic [6:0]  speed_ff, speed_in;
   logic [2:0]  last_move_ff, last_move_in;
   logic [1:0]  ldir_ff, ldir_in, rdir_ff, rdir_in;
   logic [6:0]  lpct_ff, lpct_in, rpct_ff, rpct_in;
   logic        domove_ff, domove_in;
   logic [2:0]  mv_ff, mv_in;

   logic [15:0] opnd_wide;
   logic [6:0]  opnd_narrow;
   logic [22:0] mul_a;
   logic [17:0] mul_b;
   logic [40:0] mul_p;
   logic [22:0] x_ff;
   logic [40:0] prod_ff;
   logic [16:0] q_est, q_fix;
   logic [23:0] q100;
   logic [22:0] rem;
   logic [6:0]  q_pct;
   logic [6:0]  in_ff, out_ff;
   logic [15:0] duty_l_ff, duty_r_ff;
   logic [63:0] rsp_ff;

   function automatic logic [1:0] enable_mode(input logic [15:0] duty,
                                              input logic [15:0] fs);
      if (duty == 16'd0)
         return ddcm_pkg::ModeLow;
      else if (duty == fs)
         return ddcm_pkg::ModeHigh;
      else
         return ddcm_pkg::ModePwm;
   endfunction

   assign action = req_tdata[3:0];
   assign sv_raw = req_tdata[11:4];

   always_comb begin
      case (action)
         ddcm_pkg::ActCrawl: preset = cfg.crawl_speed;
         ddcm_pkg::ActSlow:  preset = cfg.slow_speed;
         default:            preset = cfg.fast_speed;
      endcase
   end

   assign preset_clamp = (preset > ddcm_pkg::PctMax) ? ddcm_pkg::PctMax : preset;
   assign sv_clamp = sv_raw[7] ? 7'd0
                   : (sv_raw[6:0] > ddcm_pkg::PctMax) ? ddcm_pkg::PctMax : sv_raw[6:0];

   // command decode at transfer, speed updates before the move is worked out
   always_comb begin
      speed_in  = speed_ff;
      domove_in = domove_ff;
      mv_in     = mv_ff;
      if (cmd.load) begin
         case (action) inside
            ddcm_pkg::ActCrawl, ddcm_pkg::ActSlow, ddcm_pkg::ActFast: begin
               // reapply the last move; a stopped drive stays stopped
               speed_in  = preset_clamp;
               domove_in = 1'b1;
               mv_in     = last_move_ff;
            end
            [ddcm_pkg::ActForward:ddcm_pkg::ActUturn]: begin
               domove_in = 1'b1;
               mv_in     = 3'(action - ddcm_pkg::ActForward) + ddcm_pkg::MoveForward;
            end
            ddcm_pkg::ActSetSpeed: begin
               speed_in  = sv_clamp;
               domove_in = 1'b0;
            end
            default: begin
               domove_in = 1'b1;
               mv_in     = ddcm_pkg::MoveStop;
            end
         endcase
      end
   end

   // shared multiplier: operand product first, reciprocal of 100 second
   always_comb begin
      case (cmd.op)
         ddcm_pkg::OpInner: opnd_wide = {9'd0, cfg.inner_turn_pct};
         ddcm_pkg::OpOuter: opnd_wide = {9'd0, cfg.outer_turn_pct};
         default:           opnd_wide = cfg.pwm_full_scale;
      endcase
      case (cmd.op)
         ddcm_pkg::OpDutyLeft:  opnd_narrow = lpct_ff;
         ddcm_pkg::OpDutyRight: opnd_narrow = rpct_ff;
         default:               opnd_narrow = speed_ff;
      endcase
   end

   assign mul_a = cmd.mul2 ? x_ff : {7'd0, opnd_wide};
   assign mul_b = cmd.mul2 ? ddcm_pkg::RecipDiv100 : {11'd0, opnd_narrow};
   assign mul_p = {18'd0, mul_a} * {23'd0, mul_b};

   // quotient estimate is low by at most one; fix with one compare
   assign q_est = prod_ff[40:ddcm_pkg::RecipShift];
   assign q100  = {1'b0, q_est, 6'd0} + {2'b0, q_est, 5'd0} + {5'd0, q_est, 2'd0};
   assign rem   = x_ff - q100[22:0];
   assign q_fix = q_est + {16'd0, (rem >= 23'd100)};
   assign q_pct = (q_fix > 17'd100) ? ddcm_pkg::PctMax : q_fix[6:0];

   always_comb begin
      last_move_in = last_move_ff;
      ldir_in      = ldir_ff;
      rdir_in      = rdir_ff;
      lpct_in      = lpct_ff;
      rpct_in      = rpct_ff;
      if (cmd.mix && domove_ff) begin
         last_move_in = mv_ff;
         case (mv_ff)
            ddcm_pkg::MoveForward: begin
               ldir_in = ddcm_pkg::DirFwd; lpct_in = speed_ff;
               rdir_in = ddcm_pkg::DirFwd; rpct_in = speed_ff;
            end
            ddcm_pkg::MoveBack: begin
               ldir_in = ddcm_pkg::DirRev; lpct_in = speed_ff;
               rdir_in = ddcm_pkg::DirRev; rpct_in = speed_ff;
            end
            ddcm_pkg::MoveLeft: begin
               ldir_in = ddcm_pkg::DirFwd; lpct_in = in_ff;
               rdir_in = ddcm_pkg::DirFwd; rpct_in = out_ff;
            end
            ddcm_pkg::MoveRight: begin
               ldir_in = ddcm_pkg::DirFwd; lpct_in = out_ff;
               rdir_in = ddcm_pkg::DirFwd; rpct_in = in_ff;
            end
            ddcm_pkg::MoveUturn: begin
               ldir_in = ddcm_pkg::DirRev; lpct_in = in_ff;
               rdir_in = ddcm_pkg::DirFwd; rpct_in = out_ff;
            end
            default: begin
               last_move_in = ddcm_pkg::MoveStop;
               ldir_in = ddcm_pkg::DirIdle; lpct_in = 7'd0;
               rdir_in = ddcm_pkg::DirIdle; rpct_in = 7'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= ddcm_pkg::DefaultReset;
         last_move_ff <= ddcm_pkg::MoveStop;
         ldir_ff      <= ddcm_pkg::DirIdle;
         rdir_ff      <= ddcm_pkg::DirIdle;
         lpct_ff      <= 7'd0;
         rpct_ff      <= 7'd0;
      end else begin
         speed_ff     <= speed_in;
         last_move_ff <= last_move_in;
         ldir_ff      <= ldir_in;
         rdir_ff      <= rdir_in;
         lpct_ff      <= lpct_in;
         rpct_ff      <= rpct_in;
      end
   end

   always_ff @(posedge clock) begin
      domove_ff <= domove_in;
      mv_ff     <= mv_in;
      if (cmd.mul1)
         x_ff <= mul_p[22:0];
      if (cmd.mul2)
         prod_ff <= mul_p;
      if (cmd.fix) begin
         case (cmd.op)
            ddcm_pkg::OpInner: in_ff  <= q_pct;
            ddcm_pkg::OpOuter: out_ff <= q_pct;
            ddcm_pkg::OpDutyLeft:
               duty_l_ff <= (ldir_ff == ddcm_pkg::DirIdle) ? 16'd0 : q_fix[15:0];
            default:
               duty_r_ff <= (rdir_ff == ddcm_pkg::DirIdle) ? 16'd0 : q_fix[15:0];
         endcase
      end
      if (cmd.out_load) begin
         rsp_ff <= {last_move_ff, speed_ff, rpct_ff, lpct_ff,
                    enable_mode(duty_r_ff, cfg.pwm_full_scale),
                    enable_mode(duty_l_ff, cfg.pwm_full_scale),
                    duty_r_ff, duty_l_ff,
                    (rdir_ff == ddcm_pkg::DirRev), (rdir_ff == ddcm_pkg::DirFwd),
                    (ldir_ff == ddcm_pkg::DirRev), (ldir_ff == ddcm_pkg::DirFwd)};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ddcm_ctrl.sv
// ----------------------------------------------------------------------------
// Drive command mixer controller
// Sequences the four scaling passes, the mix update and the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ddcm_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output ddcm_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      StIdle = 6'b000001,
      StMul  = 6'b000010,
      StDiv  = 6'b000100,
      StFix  = 6'b001000,
      StMix  = 6'b010000,
      StDone = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               op_in    = ddcm_pkg::OpInner;
               state_in = StMul;
            end
         end
         StMul: begin
            cmd.mul1 = 1'b1;
            state_in = StDiv;
         end
         StDiv: begin
            cmd.mul2 = 1'b1;
            state_in = StFix;
         end
         StFix: begin
            cmd.fix = 1'b1;
            if (op_ff == ddcm_pkg::OpOuter) begin
               state_in = StMix;
            end else if (op_ff == ddcm_pkg::OpDutyRight) begin
               state_in = StDone;
            end else begin
               op_in    = op_ff + 2'd1;
               state_in = StMul;
            end
         end
         StMix: begin
            cmd.mix  = 1'b1;
            op_in    = ddcm_pkg::OpDutyLeft;
            state_in = StMul;
         end
         StDone: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         op_ff        <= ddcm_pkg::OpInner;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == StMul))
      else $error("accepted command did not start the multiplier pass");

   a_mix_after_outer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StMix) |-> (op_ff == ddcm_pkg::OpOuter))
      else $error("mix update outside the outer pass");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while still pending");

   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == StDone))
      else $error("result valid raised outside the done state");
`endif

endmodule

`default_nettype wire

FILE: rtl/differential_drive_command_mixer.sv
// ----------------------------------------------------------------------------
// Differential drive command mixer
// Turns drive commands into H-bridge direction pins, PWM duty and enable modes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one command per transfer, action and signed speed value.
//   rsp channel: one result per command with pins, duties, enable modes,
//   side percents, current speed and move.
//   csr port: presets, turn ratios and PWM full scale; write only while idle.
// Flow: a command is worked out in full before the next one is taken; the
//   next command is accepted only once the result is in the output register.
//   Each command takes three steps (product, reciprocal, fix) around a single
//   23x18 multiplier for each of the four scalings: inner turn, outer turn,
//   left duty, right duty.
// Reset: registers load their defaults, speed 40 percent, move stop, both
//   sides idle, no result pending.
// Stall: a finished result waits in the output register; one more command
//   is accepted and worked out meanwhile, then held until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_command_mixer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] action, [11:4] speed_value, [15:12] zero
   input  wire logic [15:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] left_fwd_pin, [1] left_rev_pin, [2] right_fwd_pin, [3] right_rev_pin,
   // [19:4] left_duty, [35:20] right_duty, [37:36] left_enable_mode,
   // [39:38] right_enable_mode, [46:40] left_percent, [53:47] right_percent,
   // [60:54] current_speed, [63:61] current_move
   output logic [63:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   ddcm_pkg::cfg_type cfg;
   ddcm_pkg::cmd_type cmd;

   assign csr_pready = 1'b1;

   ddcm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   ddcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ddcm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: sim/tb_differential_drive_command_mixer.sv
// ----------------------------------------------------------------------------
// Drive command mixer testbench
// Streams drive commands into the mixer and checks every result against an
// in-bench model of speed, held mix, duty scaling and enable modes. Covers
// gears, moves, stop codes, set_speed clamping and register extremes, then
// random commands under several register settings with random idling on
// both streams, a long output stall and a drained pause.
// ----------------------------------------------------------------------------
module tb_differential_drive_command_mixer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] ActBackward = 4'd4;
   localparam logic [3:0] ActLeft     = 4'd5;
   localparam logic [3:0] ActRight    = 4'd6;
   localparam logic [3:0] ActStop     = 4'd8;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 40;
   localparam int unsigned LongHold    = 300;

   typedef struct packed {
      logic [2:0]  current_move;
      logic [6:0]  current_speed;
      logic [6:0]  right_percent;
      logic [6:0]  left_percent;
      logic [1:0]  right_enable_mode;
      logic [1:0]  left_enable_mode;
      logic [15:0] right_duty;
      logic [15:0] left_duty;
      logic        right_rev_pin;
      logic        right_fwd_pin;
      logic        left_rev_pin;
      logic        left_fwd_pin;
   } drive_result_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] duty;
      logic        rev;
      logic        fwd;
   } side_drive_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [3:0] action, [11:4] speed_value, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [0] left_fwd_pin, [1] left_rev_pin, [2] right_fwd_pin, [3] right_rev_pin,
   // [19:4] left_duty, [35:20] right_duty, [37:36] left_enable_mode,
   // [39:38] right_enable_mode, [46:40] left_percent, [53:47] right_percent,
   // [60:54] current_speed, [63:61] current_move
   logic [63:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   differential_drive_command_mixer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mixer model state
   ddcm_pkg::cfg_type mixer_cfg;
   logic [6:0]  speed_pct;
   logic [2:0]  held_move;
   logic [1:0]  left_dir, right_dir;
   logic [6:0]  left_pct, right_pct;

   drive_result_type expected_mix[$];
   int unsigned   errors;
   int unsigned   cycle_count;
   bit            req_idle_on;
   bit            rsp_stall_on;
   int unsigned   long_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL differential_drive_command_mixer");
         $finish;
      end
   end

   function automatic logic [6:0] turn_share(logic [6:0] pct);
      int unsigned share;
      share = int'(speed_pct) * int'(pct) / 100;
      return (share > ddcm_pkg::PctMax) ? ddcm_pkg::PctMax : 7'(share);
   endfunction

   function automatic void apply_move(logic [2:0] mv);
      logic [6:0] inner;
      logic [6:0] outer;
      inner = turn_share(mixer_cfg.inner_turn_pct);
      outer = turn_share(mixer_cfg.outer_turn_pct);
      case (mv)
         ddcm_pkg::MoveForward: {left_dir, left_pct, right_dir, right_pct} =
            {ddcm_pkg::DirFwd, speed_pct, ddcm_pkg::DirFwd, speed_pct};
         ddcm_pkg::MoveBack:    {left_dir, left_pct, right_dir, right_pct} =
            {ddcm_pkg::DirRev, speed_pct, ddcm_pkg::DirRev, speed_pct};
         ddcm_pkg::MoveLeft:    {left_dir, left_pct, right_dir, right_pct} =
            {ddcm_pkg::DirFwd, inner, ddcm_pkg::DirFwd, outer};
         ddcm_pkg::MoveRight:   {left_dir, left_pct, right_dir, right_pct} =
            {ddcm_pkg::DirFwd, outer, ddcm_pkg::DirFwd, inner};
         ddcm_pkg::MoveUturn:   {left_dir, left_pct, right_dir, right_pct} =
            {ddcm_pkg::DirRev, inner, ddcm_pkg::DirFwd, outer};
         default: begin
            mv = ddcm_pkg::MoveStop;
            {left_dir, left_pct, right_dir, right_pct} =
               {ddcm_pkg::DirIdle, 7'd0, ddcm_pkg::DirIdle, 7'd0};
         end
      endcase
      held_move = mv;
   endfunction

   function automatic side_drive_type side_drive(logic [1:0] dir, logic [6:0] pct);
      side_drive_type s;
      int unsigned fs;
      int unsigned level;
      fs = mixer_cfg.pwm_full_scale;
      s.fwd = (dir == ddcm_pkg::DirFwd);
      s.rev = (dir == ddcm_pkg::DirRev);
      if (dir == ddcm_pkg::DirIdle || pct == 0)
         level = 0;
      else if (pct >= ddcm_pkg::PctMax)
         level = fs;
      else
         level = int'(pct) * fs / 100;
      if (level == 0) begin
         s.duty = 16'd0;
         s.mode = ddcm_pkg::ModeLow;
      end else if (level >= fs) begin
         s.duty = 16'(fs);
         s.mode = ddcm_pkg::ModeHigh;
      end else begin
         s.duty = 16'(level);
         s.mode = ddcm_pkg::ModePwm;
      end
      return s;
   endfunction

   function automatic drive_result_type mix_command(logic [3:0] act,
                                                    logic signed [7:0] val);
      drive_result_type r;
      side_drive_type   ls;
      side_drive_type   rs;
      logic [6:0]       preset;
      if (act <= ddcm_pkg::ActFast) begin
         case (act)
            ddcm_pkg::ActCrawl: preset = mixer_cfg.crawl_speed;
            ddcm_pkg::ActSlow:  preset = mixer_cfg.slow_speed;
            default:            preset = mixer_cfg.fast_speed;
         endcase
         speed_pct = (preset > ddcm_pkg::PctMax) ? ddcm_pkg::PctMax : preset;
         // reapply the running move at the new gear
         if (held_move != ddcm_pkg::MoveStop)
            apply_move(held_move);
      end else if (act >= ddcm_pkg::ActForward && act <= ddcm_pkg::ActUturn) begin
         apply_move(3'(act - ddcm_pkg::ActForward) + ddcm_pkg::MoveForward);
      end else if (act == ddcm_pkg::ActSetSpeed) begin
         if (val < 0)
            speed_pct = 7'd0;
         else if (val > 100)
            speed_pct = ddcm_pkg::PctMax;
         else
            speed_pct = 7'(val);
      end else begin
         apply_move(ddcm_pkg::MoveStop);
      end
      ls = side_drive(left_dir, left_pct);
      rs = side_drive(right_dir, right_pct);
      r.left_fwd_pin      = ls.fwd;
      r.left_rev_pin      = ls.rev;
      r.right_fwd_pin     = rs.fwd;
      r.right_rev_pin     = rs.rev;
      r.left_duty         = ls.duty;
      r.right_duty        = rs.duty;
      r.left_enable_mode  = ls.mode;
      r.right_enable_mode = rs.mode;
      r.left_percent      = left_pct;
      r.right_percent     = right_pct;
      r.current_speed     = speed_pct;
      r.current_move      = held_move;
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // check results, then predict for a command taken at the same edge
   always @(posedge clock) begin : monitor
      drive_result_type got;
      drive_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_mix.size() == 0) begin
               errors++;
               $display("%0t: unexpected result expected none actual %h", $time, rsp_tdata);
            end else begin
               want = expected_mix.pop_front();
               check_field("left_fwd_pin", want.left_fwd_pin, got.left_fwd_pin);
               check_field("left_rev_pin", want.left_rev_pin, got.left_rev_pin);
               check_field("right_fwd_pin", want.right_fwd_pin, got.right_fwd_pin);
               check_field("right_rev_pin", want.right_rev_pin, got.right_rev_pin);
               check_field("left_duty", want.left_duty, got.left_duty);
               check_field("right_duty", want.right_duty, got.right_duty);
               check_field("left_enable_mode", want.left_enable_mode, got.left_enable_mode);
               check_field("right_enable_mode", want.right_enable_mode,
                           got.right_enable_mode);
               check_field("left_percent", want.left_percent, got.left_percent);
               check_field("right_percent", want.right_percent, got.right_percent);
               check_field("current_speed", want.current_speed, got.current_speed);
               check_field("current_move", want.current_move, got.current_move);
            end
         end
         if (req_tvalid && req_tready)
            expected_mix.push_back(mix_command(req_tdata[3:0], req_tdata[11:4]));
      end
   end

   // result side: random stall per transfer, or one long hold when asked
   initial begin : receiver
      int unsigned pause;
      rsp_tready = 1'b0;
      forever begin
         pause = rsp_stall_on ? $urandom_range(0, 10) : 0;
         if (long_hold_cycles != 0) begin
            pause = long_hold_cycles;
            long_hold_cycles = 0;
         end
         repeat (pause) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // leave valid high on return so back-to-back commands need no gap
   task automatic send_command(logic [3:0] act, logic signed [7:0] val);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0000, val, act};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_mix.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         ddcm_pkg::RegCrawl:     mixer_cfg.crawl_speed    = value[6:0];
         ddcm_pkg::RegSlow:      mixer_cfg.slow_speed     = value[6:0];
         ddcm_pkg::RegFast:      mixer_cfg.fast_speed     = value[6:0];
         ddcm_pkg::RegDefault:   mixer_cfg.default_speed  = value[6:0];
         ddcm_pkg::RegInner:     mixer_cfg.inner_turn_pct = value[6:0];
         ddcm_pkg::RegOuter:     mixer_cfg.outer_turn_pct = value[6:0];
         ddcm_pkg::RegFullScale: mixer_cfg.pwm_full_scale = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic test_directed_moves();
      send_command(ddcm_pkg::ActForward, 8'sd0);
      send_command(ddcm_pkg::ActSetSpeed, 8'sd127);
      send_command(ActBackward, 8'sd0);
      send_command(ddcm_pkg::ActSetSpeed, -8'sd128);
      send_command(ActLeft, 8'sd0);
      send_command(ddcm_pkg::ActSetSpeed, 8'sd100);
      send_command(ActRight, 8'sd0);
      send_command(ddcm_pkg::ActUturn, -8'sd1);
      send_command(ddcm_pkg::ActCrawl, 8'sd0);
      send_command(ddcm_pkg::ActSlow, 8'sd0);
      send_command(ddcm_pkg::ActFast, 8'sd0);
      send_command(ActStop, 8'sd0);
      send_command(ddcm_pkg::ActCrawl, 8'sd55);
      send_command(4'd10, 8'sd0);
      send_command(4'd15, -8'sd1);
      send_command(ddcm_pkg::ActSetSpeed, 8'sd101);
      wait_drain();
   endtask

   task automatic test_register_extremes();
      // presets and turn share above 100, zero full scale
      csr_write(ddcm_pkg::RegCrawl, 32'd127);
      csr_write(ddcm_pkg::RegSlow, 32'd0);
      csr_write(ddcm_pkg::RegFast, 32'd100);
      csr_write(ddcm_pkg::RegDefault, 32'd127);
      csr_write(ddcm_pkg::RegInner, 32'd0);
      csr_write(ddcm_pkg::RegOuter, 32'd127);
      csr_write(ddcm_pkg::RegFullScale, 32'd0);
      send_command(ddcm_pkg::ActSetSpeed, 8'sd100);
      send_command(ActLeft, 8'sd0);
      send_command(ddcm_pkg::ActCrawl, 8'sd0);
      send_command(ddcm_pkg::ActUturn, 8'sd0);
      wait_drain();
      csr_write(ddcm_pkg::RegFullScale, 32'd1);
      csr_write(ddcm_pkg::RegInner, 32'd127);
      send_command(ActRight, 8'sd0);
      send_command(ddcm_pkg::ActSlow, 8'sd0);
      wait_drain();
      csr_write(ddcm_pkg::RegFullScale, 32'd65535);
      send_command(ddcm_pkg::ActFast, 8'sd0);
      send_command(ddcm_pkg::ActUturn, 8'sd0);
      wait_drain();
   endtask

   task automatic randomize_registers();
      logic [2:0]  idx;
      logic [31:0] value;
      for (int i = 0; i < 6; i++) begin
         idx   = 3'(i);
         value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(0, 100);
         csr_write(idx, value);
      end
      case ($urandom_range(0, 4))
         0: value = $urandom_range(1, 65535);
         1: value = $urandom_range(1, 1023);
         2: value = 32'd65535;
         3: value = 32'd100;
         default: value = $urandom_range(0, 127);
      endcase
      csr_write(ddcm_pkg::RegFullScale, value);
   endtask

   task automatic test_random_commands(int unsigned count);
      logic [3:0] act;
      for (int unsigned i = 0; i < count; i++) begin
         act = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
         send_command(act, 8'($urandom_range(0, 255)));
      end
      wait_drain();
   endtask

   task automatic test_output_stall();
      // hold the result side long enough to back up the command side
      long_hold_cycles = LongHold;
      for (int i = 0; i < 10; i++)
         send_command(4'($urandom_range(0, 9)), 8'($urandom_range(0, 255)));
      wait_drain();
   endtask

   task automatic test_sender_pause();
      for (int i = 0; i < 6; i++)
         send_command(4'($urandom_range(0, 9)), 8'($urandom_range(0, 255)));
      wait_drain();
      for (int i = 0; i < 6; i++)
         send_command(4'($urandom_range(0, 9)), 8'($urandom_range(0, 255)));
      wait_drain();
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = 16'd0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = 5'd0;
      csr_pwdata       = 32'd0;
      errors           = 0;
      cycle_count      = 0;
      req_idle_on      = 1'b1;
      rsp_stall_on     = 1'b1;
      long_hold_cycles = 0;
      mixer_cfg = '{crawl_speed: ddcm_pkg::CrawlReset,
                    slow_speed: ddcm_pkg::SlowReset,
                    fast_speed: ddcm_pkg::FastReset,
                    default_speed: ddcm_pkg::DefaultReset,
                    inner_turn_pct: ddcm_pkg::InnerReset,
                    outer_turn_pct: ddcm_pkg::OuterReset,
                    pwm_full_scale: ddcm_pkg::FullScaleReset};
      speed_pct = (ddcm_pkg::DefaultReset > ddcm_pkg::PctMax) ? ddcm_pkg::PctMax
                                                              : ddcm_pkg::DefaultReset;
      held_move = ddcm_pkg::MoveStop;
      {left_dir, left_pct, right_dir, right_pct} =
         {ddcm_pkg::DirIdle, 7'd0, ddcm_pkg::DirIdle, 7'd0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_moves();
      test_register_extremes();
      for (int phase = 0; phase < 6; phase++) begin
         randomize_registers();
         req_idle_on  = (phase != 2);
         rsp_stall_on = (phase != 2);
         test_random_commands(240);
         if (phase == 1)
            test_output_stall();
         if (phase == 3)
            test_sender_pause();
      end
      wait_drain();

      if (errors == 0)
         $display("PASS differential_drive_command_mixer");
      else
         $display("FAIL differential_drive_command_mixer");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ddcm_pkg.sv
rtl/ddcm_regs.sv
rtl/ddcm_dpath.sv
rtl/ddcm_ctrl.sv
rtl/differential_drive_command_mixer.sv
sim/tb_differential_drive_command_mixer.sv
